/* hw/rtl/assert_macros.svh */
// assertion macros for the checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HSEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsec check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define HSEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsec check failed: next-cycle implication");

`endif

/* hw/rtl/hsec_pkg.sv */
// shared types, constants and helpers of the haplotype switch error counter
// no dependencies
`default_nettype none

package hsec_pkg;

    localparam int MAX_SAMPLES  = 1024;
    localparam int SAMPLE_BITS  = $clog2(MAX_SAMPLES);
    localparam int SITE_BITS    = 24;
    localparam int COUNT_BITS   = 32;
    localparam int SCOUNT_BITS  = 16;
    localparam int CLASS_COUNT  = 4;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIO_MODE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCAL_ANC = 1'b1;

    // trio modes
    localparam logic [1:0] TRIO_NONE       = 2'd0;
    localparam logic [1:0] TRIO_SUCCESSIVE = 2'd1;
    localparam logic [1:0] TRIO_PAIRED     = 2'd2;
    localparam logic [1:0] TRIO_RESERVED   = 2'd3;

    localparam logic [1:0] CLASS_AMBIG = 2'd3;

    typedef enum logic [2:0] {
        OUT_COMPARED      = 3'd0,
        OUT_TRUTH_MISSING = 3'd1,
        OUT_TRIO_AMBIG    = 3'd2,
        OUT_PARTNER_SKIP  = 3'd3,
        OUT_EST_MISSING   = 3'd4,
        OUT_UNANCHORED    = 3'd5,
        OUT_ANCHORED      = 3'd6
    } outcome_t;

    typedef enum logic [1:0] {
        ORIENT_UNKNOWN  = 2'd0,
        ORIENT_DIRECT   = 2'd1,
        ORIENT_INVERTED = 2'd2
    } orient_t;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic [1:0]             pad;
        logic [1:0]             ancestry_class;
        logic                   partner_true_b;
        logic                   partner_true_a;
        logic [1:0]             est_b;
        logic [1:0]             est_a;
        logic [1:0]             true_b;
        logic [1:0]             true_a;
        logic [SITE_BITS-1:0]   site_index;
        logic [SAMPLE_BITS-1:0] sample_index;
    } hsec_in_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [SITE_BITS-1:0]   block_length;
        logic [SCOUNT_BITS-1:0] sample_switches;
        logic [COUNT_BITS-1:0]  class_het;
        logic [COUNT_BITS-1:0]  class_switches;
        logic [COUNT_BITS-1:0]  total_missing;
        logic [COUNT_BITS-1:0]  total_het;
        logic [COUNT_BITS-1:0]  total_switches;
        logic                   consistency_error;
        logic [1:0]             class_used;
        logic                   het_counted;
        logic                   switch_error;
        outcome_t               outcome;
    } hsec_out_t;

    localparam int IN_BITS  = $bits(hsec_in_t);
    localparam int OUT_BITS = $bits(hsec_out_t);

    // per-sample record held in the sample memory
    typedef struct packed {
        orient_t                orient;
        logic [1:0]             prev_anc;
        logic [SITE_BITS-1:0]   last_site;
        logic [SCOUNT_BITS-1:0] count;
    } hsec_rec_t;

    localparam hsec_rec_t REC_RESET = '{
        orient:    ORIENT_UNKNOWN,
        prev_anc:  CLASS_AMBIG,
        last_site: '0,
        count:     '0
    };

    // evaluation of one item against its record
    typedef struct packed {
        outcome_t               outcome;
        logic                   sw;
        logic                   het;
        logic                   cerr;
        logic [1:0]             cls;
        logic                   skip_next;
        logic [SITE_BITS-1:0]   block_length;
        logic [SCOUNT_BITS-1:0] sample_switches;
        hsec_rec_t              rec_next;
    } hsec_eval_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hsec_eval.sv */
// per-item evaluation: outcome, switch detection and next per-sample record
// depends on hsec_pkg
`default_nettype none

module hsec_eval
    import hsec_pkg::*;
(
    input  wire logic [1:0] trio_mode,
    input  wire logic       use_local_ancestry,
    input  wire logic       skip_partner,
    input  wire hsec_in_t   item,
    input  wire hsec_rec_t  rec,
    output hsec_eval_t      res
);

    logic [1:0] mode;
    logic [1:0] cls;
    logic       truth_missing;
    logic       est_missing;
    logic       trio_ambig;
    logic       inverted;
    logic [1:0] e0;
    logic [1:0] e1;

    assign mode          = (trio_mode == TRIO_RESERVED) ? TRIO_NONE : trio_mode;
    assign cls           = (use_local_ancestry && item.ancestry_class != CLASS_AMBIG
                            && item.ancestry_class == rec.prev_anc)
                           ? item.ancestry_class : CLASS_AMBIG;
    assign truth_missing = item.true_a[1] | item.true_b[1];
    assign est_missing   = item.est_a[1] | item.est_b[1];
    // triple-het: child het, partner het, transmitted alleles disagree
    assign trio_ambig    = ((mode == TRIO_SUCCESSIVE && !item.sample_index[0])
                            || mode == TRIO_PAIRED)
                           && item.true_a != item.true_b
                           && item.partner_true_a != item.partner_true_b
                           && item.true_a[0] != item.partner_true_a;
    assign inverted      = (rec.orient == ORIENT_INVERTED);
    assign e0            = inverted ? item.est_b : item.est_a;
    assign e1            = inverted ? item.est_a : item.est_b;

    always_comb
    begin
        res                 = '0;
        res.outcome         = OUT_COMPARED;
        res.cls             = cls;
        res.skip_next       = skip_partner;
        res.block_length    = item.site_index - rec.last_site;
        res.sample_switches = rec.count;
        res.rec_next        = rec;
        if (use_local_ancestry)
        begin
            res.rec_next.prev_anc = item.ancestry_class;
        end

        if (skip_partner)
        begin
            res.outcome   = OUT_PARTNER_SKIP;
            res.skip_next = 1'b0;
        end
        else if (truth_missing)
        begin
            res.outcome = OUT_TRUTH_MISSING;
        end
        else if (trio_ambig)
        begin
            res.outcome = OUT_TRIO_AMBIG;
            if (mode == TRIO_SUCCESSIVE)
            begin
                res.skip_next = 1'b1;
            end
        end
        else if (est_missing)
        begin
            res.outcome = OUT_EST_MISSING;
            res.cerr    = (item.est_a != item.est_b);
        end
        else if (rec.orient == ORIENT_UNKNOWN)
        begin
            if (item.true_a == item.true_b)
            begin
                res.outcome = OUT_UNANCHORED;
                res.cerr    = (item.est_a != item.est_b) || (item.est_a != item.true_a);
            end
            else
            begin
                res.outcome = OUT_ANCHORED;
                if (item.est_a == item.true_a)
                begin
                    res.rec_next.orient = ORIENT_DIRECT;
                    res.cerr            = (item.est_b != item.true_b);
                end
                else
                begin
                    res.rec_next.orient = ORIENT_INVERTED;
                    res.cerr = (item.est_a != item.true_b) || (item.est_b != item.true_a);
                end
            end
        end
        else
        begin
            res.outcome = OUT_COMPARED;
            res.het     = (item.true_a != item.true_b);
            if (e0 == item.true_a)
            begin
                res.cerr = (e1 != item.true_b);
            end
            else
            begin
                res.cerr               = (e0 != item.true_b) || (e1 != item.true_a);
                res.sw                 = 1'b1;
                res.rec_next.orient    = inverted ? ORIENT_DIRECT : ORIENT_INVERTED;
                res.rec_next.last_site = item.site_index;
                res.rec_next.count     = (rec.count == {SCOUNT_BITS{1'b1}})
                                         ? rec.count : rec.count + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/haplotype_switch_error_counter.sv */
// haplotype switch error counter, top level: sample memory, counters, handshakes
// depends on hsec_pkg and hsec_eval
`default_nettype none

// Takes one (sample, site) item per transfer and returns one result per item,
// in order. Throughput is one item per clock while the result stream does not
// stall and no clearing pass runs. The item and its per-sample record are
// registered together at the transfer, and evaluation goes into the output
// register once that register is free or draining. The sample memory is
// read once per accepted item and written once per evaluated item; a
// back-to-back item of the same sample gets the freshly computed record
// through a bypass on the read register. After reset a clearing pass writes
// the reset record into all 1024 sample entries, one per cycle, so s_tready
// stays low during the pass; configuration writes are taken throughout. Global and
// per-class counters saturate at all ones, the per-sample switch count at 65535.
// Configuration: index 0 trio_mode (2 bits), index 1 use_local_ancestry
// (bit 0); write only while no item is in flight.

module haplotype_switch_error_counter
    import hsec_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input stream
    input  wire logic                      s_tvalid,
    output      logic                      s_tready,
    // fields from bit 0 up: sample_index, site_index, true_a, true_b,
    // est_a, est_b, partner_true_a, partner_true_b, ancestry_class, zero pad
    input  wire logic [IN_BITS-1:0]        s_tdata,
    // result stream
    output      logic                      m_tvalid,
    input  wire logic                      m_tready,
    // fields from bit 0 up: outcome, switch_error, het_counted, class_used,
    // consistency_error, total_switches, total_het, total_missing,
    // class_switches, class_het, sample_switches, block_length
    output      logic [OUT_BITS-1:0]       m_tdata,
    // configuration write channel
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // configuration registers
    logic [1:0] trio_mode_reg;
    logic       local_anc_reg;

    // clearing pass over the sample memory
    logic                   clearing_reg;
    logic [SAMPLE_BITS-1:0] clr_addr_reg;

    // sample memory and its registered read
    hsec_rec_t mem [MAX_SAMPLES];
    hsec_rec_t rd_rec_reg;

    // evaluation stage
    logic     s1_valid_reg;
    hsec_in_t s1_item_reg;
    logic     skip_reg;

    // running totals
    logic [COUNT_BITS-1:0] glob_sw_reg;
    logic [COUNT_BITS-1:0] glob_het_reg;
    logic [COUNT_BITS-1:0] glob_miss_reg;
    logic [COUNT_BITS-1:0] cls_sw_reg  [CLASS_COUNT];
    logic [COUNT_BITS-1:0] cls_het_reg [CLASS_COUNT];

    logic [COUNT_BITS-1:0] glob_sw_next;
    logic [COUNT_BITS-1:0] glob_het_next;
    logic [COUNT_BITS-1:0] glob_miss_next;
    logic [COUNT_BITS-1:0] cls_sw_next;
    logic [COUNT_BITS-1:0] cls_het_next;

    // output register
    logic      out_valid_reg;
    hsec_out_t out_data_reg;
    hsec_out_t out_next;

    hsec_in_t   in_item;
    hsec_eval_t ev;
    logic       s1_fire;
    logic       in_fire;
    logic       bypass;

    assign in_item = hsec_in_t'(s_tdata);

    // evaluation advances whenever the output register is free or draining
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_fire);
    assign in_fire  = s_tvalid && s_tready;
    // same sample back to back: take the record being written this cycle
    assign bypass   = s1_fire && (s1_item_reg.sample_index == in_item.sample_index);

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    hsec_eval u_eval (
        .trio_mode          (trio_mode_reg),
        .use_local_ancestry (local_anc_reg),
        .skip_partner       (skip_reg),
        .item               (s1_item_reg),
        .rec                (rd_rec_reg),
        .res                (ev)
    );

    // counter updates for the item under evaluation
    always_comb
    begin
        glob_sw_next   = ev.sw  ? sat_inc(glob_sw_reg)  : glob_sw_reg;
        glob_het_next  = ev.het ? sat_inc(glob_het_reg) : glob_het_reg;
        glob_miss_next = (ev.outcome == OUT_EST_MISSING) ? sat_inc(glob_miss_reg)
                                                         : glob_miss_reg;
        cls_sw_next    = ev.sw  ? sat_inc(cls_sw_reg[ev.cls])  : cls_sw_reg[ev.cls];
        cls_het_next   = ev.het ? sat_inc(cls_het_reg[ev.cls]) : cls_het_reg[ev.cls];
    end

    // result assembly
    always_comb
    begin
        out_next.outcome           = ev.outcome;
        out_next.switch_error      = ev.sw;
        out_next.het_counted       = ev.het;
        out_next.class_used        = ev.cls;
        out_next.consistency_error = ev.cerr;
        out_next.total_switches    = glob_sw_next;
        out_next.total_het         = glob_het_next;
        out_next.total_missing     = glob_miss_next;
        out_next.class_switches    = cls_sw_next;
        out_next.class_het         = cls_het_next;
        out_next.sample_switches   = ev.sample_switches;
        out_next.block_length      = ev.block_length;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trio_mode_reg <= TRIO_NONE;
            local_anc_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TRIO_MODE: trio_mode_reg <= cfg_data;
                CFG_LOCAL_ANC: local_anc_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == SAMPLE_BITS'(MAX_SAMPLES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // sample memory: one write port, one registered read port with bypass
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= REC_RESET;
        end
        else if (s1_fire)
        begin
            mem[s1_item_reg.sample_index] <= ev.rec_next;
        end
        if (in_fire)
        begin
            if (bypass)
            begin
                rd_rec_reg <= ev.rec_next;
            end
            else
            begin
                rd_rec_reg <= mem[in_item.sample_index];
            end
        end
    end

    // evaluation stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
    end

    // partner skip flag and running totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= 1'b0;
            glob_sw_reg   <= '0;
            glob_het_reg  <= '0;
            glob_miss_reg <= '0;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                cls_sw_reg[i]  <= '0;
                cls_het_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            skip_reg             <= ev.skip_next;
            glob_sw_reg          <= glob_sw_next;
            glob_het_reg         <= glob_het_next;
            glob_miss_reg        <= glob_miss_next;
            cls_sw_reg[ev.cls]   <= cls_sw_next;
            cls_het_reg[ev.cls]  <= cls_het_next;
        end
    end

    // output register: holds a result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hsec_checker.sv */
// port-level checks on the result stream of the switch error counter, and its bind
// depends on hsec_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module hsec_checker
    import hsec_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [OUT_BITS-1:0] m_tdata
);

    hsec_out_t res;

    assign res = hsec_out_t'(m_tdata);

    // a stalled result holds
    `HSEC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a switch only comes from a compared site and is already in the total
    `HSEC_ASSERT_NOW(a_switch_compared, m_tvalid && res.switch_error,
        res.outcome == OUT_COMPARED && res.total_switches != '0 && res.class_switches != '0)

    // a het count only comes from a compared site and is already in the totals
    `HSEC_ASSERT_NOW(a_het_compared, m_tvalid && res.het_counted,
        res.outcome == OUT_COMPARED && res.total_het != '0 && res.class_het != '0)

    // a missing estimate is counted and never compared
    `HSEC_ASSERT_NOW(a_missing_counted, m_tvalid && res.outcome == OUT_EST_MISSING,
        res.total_missing != '0 && !res.switch_error && !res.het_counted)

endmodule

bind haplotype_switch_error_counter hsec_checker u_hsec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/tb_haplotype_switch_error_counter.sv */
// self-checking testbench of the haplotype switch error counter: directed site table, then
// random site streams with both sides idling; depends on hsec_pkg and the counter's top level
module tb_haplotype_switch_error_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import hsec_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int LONG_HOLD    = 150;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 220;

    typedef enum {ROW_SITE, ROW_REG} row_kind_t;

    // one line of the directed table: either a site transfer or a register write;
    // typed rows carry the outcome and flags that the site must produce
    typedef struct {
        row_kind_t                 kind;
        hsec_in_t                  item;
        logic [CFG_INDEX_BITS-1:0] reg_idx;
        logic [CFG_DATA_BITS-1:0]  reg_val;
        bit                        typed;
        outcome_t                  outcome;
        bit                        sw;
        bit                        cerr;
    } stim_row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_BITS-1:0]        s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_BITS-1:0]       m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // idling controls for the sender and the receiver, set by the stimulus
    bit tx_idle   = 1'b1;
    bit rx_idle   = 1'b1;
    bit long_hold = 1'b0;
    int failures  = 0;

    // predicted state of the block
    orient_t                orient_q [MAX_SAMPLES];
    logic [1:0]             prev_anc_q [MAX_SAMPLES];
    logic [SITE_BITS-1:0]   switch_site_q [MAX_SAMPLES];
    logic [SCOUNT_BITS-1:0] sample_sw_q [MAX_SAMPLES];
    logic [COUNT_BITS-1:0]  class_sw_q [CLASS_COUNT];
    logic [COUNT_BITS-1:0]  class_het_q [CLASS_COUNT];
    logic [COUNT_BITS-1:0]  total_sw_q;
    logic [COUNT_BITS-1:0]  total_het_q;
    logic [COUNT_BITS-1:0]  total_missing_q;
    bit                     skip_next_q;
    logic [1:0]             trio_mode_q;
    bit                     strat_q;

    hsec_out_t site_scores_q [$];
    stim_row_t stim_table [$];

    haplotype_switch_error_counter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // scores one site against the predicted per-sample record and the totals
    function automatic hsec_out_t score_site(input hsec_in_t it);
        hsec_out_t              r;
        logic [SAMPLE_BITS-1:0] smp;
        logic [1:0]             cls;
        logic [1:0]             mode;
        logic [1:0]             e0;
        logic [1:0]             e1;
        r    = '0;
        smp  = it.sample_index;
        cls  = CLASS_AMBIG;
        mode = (trio_mode_q == TRIO_RESERVED) ? TRIO_NONE : trio_mode_q;
        // the credited class needs the same confident class twice in a row
        if (strat_q)
        begin
            if (it.ancestry_class != CLASS_AMBIG && it.ancestry_class == prev_anc_q[smp])
                cls = it.ancestry_class;
            prev_anc_q[smp] = it.ancestry_class;
        end
        r.block_length    = it.site_index - switch_site_q[smp];
        r.sample_switches = sample_sw_q[smp];
        if (skip_next_q)
        begin
            skip_next_q = 1'b0;
            r.outcome   = OUT_PARTNER_SKIP;
        end
        else if (it.true_a[1] || it.true_b[1])
            r.outcome = OUT_TRUTH_MISSING;
        else if (((mode == TRIO_SUCCESSIVE && !smp[0]) || mode == TRIO_PAIRED) &&
                 it.true_a != it.true_b && it.partner_true_a != it.partner_true_b &&
                 it.true_a[0] != it.partner_true_a)
        begin
            r.outcome = OUT_TRIO_AMBIG;
            if (mode == TRIO_SUCCESSIVE)
                skip_next_q = 1'b1;
        end
        else if (it.est_a[1] || it.est_b[1])
        begin
            r.outcome           = OUT_EST_MISSING;
            total_missing_q     = bump(total_missing_q);
            r.consistency_error = (it.est_a != it.est_b);
        end
        else if (orient_q[smp] == ORIENT_UNKNOWN)
        begin
            if (it.true_a == it.true_b)
            begin
                r.outcome           = OUT_UNANCHORED;
                r.consistency_error = (it.est_a != it.est_b || it.est_a != it.true_a);
            end
            else
            begin
                // first het site fixes the orientation
                r.outcome = OUT_ANCHORED;
                if (it.est_a == it.true_a)
                begin
                    orient_q[smp]       = ORIENT_DIRECT;
                    r.consistency_error = (it.est_b != it.true_b);
                end
                else
                begin
                    orient_q[smp]       = ORIENT_INVERTED;
                    r.consistency_error = (it.est_a != it.true_b || it.est_b != it.true_a);
                end
            end
        end
        else
        begin
            e0        = (orient_q[smp] == ORIENT_INVERTED) ? it.est_b : it.est_a;
            e1        = (orient_q[smp] == ORIENT_INVERTED) ? it.est_a : it.est_b;
            r.outcome = OUT_COMPARED;
            if (it.true_a != it.true_b)
            begin
                r.het_counted    = 1'b1;
                total_het_q      = bump(total_het_q);
                class_het_q[cls] = bump(class_het_q[cls]);
            end
            if (e0 == it.true_a)
                r.consistency_error = (e1 != it.true_b);
            else
            begin
                // mismatch under the current orientation: a switch, orientation flips
                r.consistency_error = (e0 != it.true_b || e1 != it.true_a);
                r.switch_error      = 1'b1;
                total_sw_q          = bump(total_sw_q);
                class_sw_q[cls]     = bump(class_sw_q[cls]);
                orient_q[smp]       = (orient_q[smp] == ORIENT_INVERTED) ? ORIENT_DIRECT
                                                                         : ORIENT_INVERTED;
                switch_site_q[smp]  = it.site_index;
                if (sample_sw_q[smp] != {SCOUNT_BITS{1'b1}})
                    sample_sw_q[smp] = sample_sw_q[smp] + 1'b1;
            end
        end
        r.class_used     = cls;
        r.total_switches = total_sw_q;
        r.total_het      = total_het_q;
        r.total_missing  = total_missing_q;
        r.class_switches = class_sw_q[cls];
        r.class_het      = class_het_q[cls];
        return r;
    endfunction

    function automatic hsec_in_t site_item(input int smp, input int site, input int ta,
                                           input int tb, input int ea, input int eb,
                                           input int pa, input int pb, input int anc);
        hsec_in_t it;
        it                = '0;
        it.sample_index   = SAMPLE_BITS'(smp);
        it.site_index     = SITE_BITS'(site);
        it.true_a         = 2'(ta);
        it.true_b         = 2'(tb);
        it.est_a          = 2'(ea);
        it.est_b          = 2'(eb);
        it.partner_true_a = 1'(pa);
        it.partner_true_b = 1'(pb);
        it.ancestry_class = 2'(anc);
        return it;
    endfunction

    function automatic void add_row(input hsec_in_t it, input int typed = 0,
                                    input outcome_t o = OUT_COMPARED, input int sw = 0,
                                    input int cerr = 0);
        stim_row_t row;
        row.kind    = ROW_SITE;
        row.item    = it;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.typed   = (typed != 0);
        row.outcome = o;
        row.sw      = (sw != 0);
        row.cerr    = (cerr != 0);
        stim_table.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
        stim_row_t row;
        row.kind    = ROW_REG;
        row.item    = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        row.typed   = 1'b0;
        row.outcome = OUT_COMPARED;
        row.sw      = 1'b0;
        row.cerr    = 1'b0;
        stim_table.push_back(row);
    endfunction

    // offers one site, waits for its transfer and records what it must score
    task automatic send_site(input hsec_in_t it, input bit typed, input outcome_t o,
                             input bit sw, input bit cerr);
        int        gap;
        hsec_out_t want;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        want = score_site(it);
        if (typed)
        begin
            want.outcome           = o;
            want.switch_error      = sw;
            want.consistency_error = cerr;
        end
        site_scores_q.push_back(want);
    endtask

    // register writes only once the pipeline has drained
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        s_tvalid <= 1'b0;
        while (site_scores_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TRIO_MODE)
            trio_mode_q = val;
        else
            strat_q = val[0];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            failures++;
        end
    endtask

    // receiver: stalls per result, plus one long hold-off on request
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold)
            begin
                stall     = LONG_HOLD;
                long_hold = 1'b0;
            end
            else
                stall = rx_idle ? $urandom_range(0, 19) : 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // result checker: every transfer against the oldest prediction
    always @(posedge clk)
    begin : result_check
        hsec_out_t want;
        hsec_out_t got;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (site_scores_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                failures++;
            end
            else
            begin
                want = site_scores_q.pop_front();
                check_field("outcome", 32'(want.outcome), 32'(got.outcome));
                check_field("switch_error", 32'(want.switch_error), 32'(got.switch_error));
                check_field("het_counted", 32'(want.het_counted), 32'(got.het_counted));
                check_field("class_used", 32'(want.class_used), 32'(got.class_used));
                check_field("consistency_error", 32'(want.consistency_error),
                            32'(got.consistency_error));
                check_field("total_switches", want.total_switches, got.total_switches);
                check_field("total_het", want.total_het, got.total_het);
                check_field("total_missing", want.total_missing, got.total_missing);
                check_field("class_switches", want.class_switches, got.class_switches);
                check_field("class_het", want.class_het, got.class_het);
                check_field("sample_switches", 32'(want.sample_switches),
                            32'(got.sample_switches));
                check_field("block_length", 32'(want.block_length), 32'(got.block_length));
            end
        end
    end

    initial
    begin : stimulus
        hsec_in_t               it;
        stim_row_t              row;
        logic [1:0]             anc_hint [MAX_SAMPLES];
        logic [1:0]             tmp;
        logic [1:0]             mode;
        logic [1:0]             anc_reg;
        logic [SAMPLE_BITS-1:0] pool_base;
        int                     k;

        for (int i = 0; i < MAX_SAMPLES; i++)
        begin
            orient_q[i]      = ORIENT_UNKNOWN;
            prev_anc_q[i]    = CLASS_AMBIG;
            switch_site_q[i] = '0;
            sample_sw_q[i]   = '0;
            anc_hint[i]      = 2'($urandom_range(0, 3));
        end
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            class_sw_q[i]  = '0;
            class_het_q[i] = '0;
        end
        total_sw_q      = '0;
        total_het_q     = '0;
        total_missing_q = '0;
        skip_next_q     = 1'b0;
        trio_mode_q     = TRIO_NONE;
        strat_q         = 1'b0;

        // directed table: sample, site, true pair, estimated pair, partner pair, ancestry
        add_reg(CFG_TRIO_MODE, TRIO_NONE);
        add_reg(CFG_LOCAL_ANC, 2'd0);
        add_row(site_item(0, 0, 2, 0, 0, 0, 0, 0, 0), 1, OUT_TRUTH_MISSING, 0, 0);
        add_row(site_item(0, 1, 1, 3, 1, 1, 1, 1, 3), 1, OUT_TRUTH_MISSING, 0, 0);
        add_row(site_item(0, 2, 0, 0, 2, 3, 0, 0, 0), 1, OUT_EST_MISSING, 0, 1);
        add_row(site_item(0, 3, 1, 1, 3, 3, 0, 0, 0), 1, OUT_EST_MISSING, 0, 0);
        add_row(site_item(0, 4, 0, 0, 0, 0, 0, 0, 0), 1, OUT_UNANCHORED, 0, 0);
        add_row(site_item(0, 5, 1, 1, 0, 1, 0, 0, 0), 1, OUT_UNANCHORED, 0, 1);
        // anchor direct, agree, switch, agree inverted, inconsistent switch
        add_row(site_item(0, 6, 0, 1, 0, 1, 0, 0, 0), 1, OUT_ANCHORED, 0, 0);
        add_row(site_item(0, 7, 1, 0, 1, 0, 0, 0, 0), 1, OUT_COMPARED, 0, 0);
        add_row(site_item(0, 8, 0, 1, 1, 0, 0, 0, 0), 1, OUT_COMPARED, 1, 0);
        add_row(site_item(0, 9, 0, 1, 1, 0, 0, 0, 0), 1, OUT_COMPARED, 0, 0);
        add_row(site_item(0, 10, 0, 0, 1, 1, 0, 0, 0), 1, OUT_COMPARED, 1, 1);
        // top sample at the top site, then a block length that wraps
        add_row(site_item(1023, 'hFFFFFF, 0, 1, 1, 0, 1, 1, 3), 1, OUT_ANCHORED, 0, 0);
        add_row(site_item(1023, 'hFFFFFF, 1, 0, 1, 0, 0, 0, 3), 1, OUT_COMPARED, 1, 0);
        add_row(site_item(1023, 3, 1, 0, 1, 0, 0, 0, 3));
        add_row(site_item(5, 100, 0, 1, 0, 0, 0, 0, 0), 1, OUT_ANCHORED, 0, 1);
        // paired trio mode with ancestry classes
        add_reg(CFG_TRIO_MODE, TRIO_PAIRED);
        add_reg(CFG_LOCAL_ANC, 2'd1);
        add_row(site_item(6, 20, 0, 1, 0, 1, 1, 0, 1), 1, OUT_TRIO_AMBIG, 0, 0);
        add_row(site_item(6, 21, 1, 0, 1, 0, 1, 0, 1));
        add_row(site_item(6, 22, 0, 1, 1, 0, 0, 0, 1), 1, OUT_COMPARED, 1, 0);
        // successive trio mode: even triple het skips the next site, odd one does not
        add_reg(CFG_TRIO_MODE, TRIO_SUCCESSIVE);
        add_row(site_item(2, 30, 1, 0, 1, 0, 0, 1, 2), 1, OUT_TRIO_AMBIG, 0, 0);
        add_row(site_item(9, 31, 0, 0, 0, 0, 0, 0, 2), 1, OUT_PARTNER_SKIP, 0, 0);
        add_row(site_item(3, 32, 1, 0, 1, 0, 0, 1, 0), 1, OUT_ANCHORED, 0, 0);
        add_row(site_item(0, 33, 0, 1, 0, 1, 1, 0, 0), 1, OUT_TRIO_AMBIG, 0, 0);
        // pending skip survives a mode change; reserved mode and data bit 1 only
        add_reg(CFG_TRIO_MODE, TRIO_RESERVED);
        add_reg(CFG_LOCAL_ANC, 2'd2);
        add_row(site_item(4, 40, 0, 1, 0, 1, 1, 0, 1), 1, OUT_PARTNER_SKIP, 0, 0);
        add_row(site_item(4, 41, 0, 1, 0, 1, 1, 0, 1), 1, OUT_ANCHORED, 0, 0);

        wait (rst_n === 1'b1);
        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.kind == ROW_REG)
                write_reg(row.reg_idx, row.reg_val);
            else
                send_site(row.item, row.typed, row.outcome, row.sw, row.cerr);
        end

        // random part: each phase a setting, a small pool of busy samples plus strays
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin mode = TRIO_SUCCESSIVE; anc_reg = 2'd1; end
                1:       begin mode = TRIO_PAIRED;     anc_reg = 2'd1; end
                2:       begin mode = TRIO_NONE;       anc_reg = 2'd0; end
                3:       begin mode = TRIO_RESERVED;   anc_reg = 2'd3; end
                default:
                begin
                    mode    = 2'($urandom_range(0, 3));
                    anc_reg = 2'($urandom_range(0, 3));
                end
            endcase
            write_reg(CFG_TRIO_MODE, mode);
            write_reg(CFG_LOCAL_ANC, anc_reg);
            pool_base = SAMPLE_BITS'($urandom_range(0, 1023));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                begin
                    tx_idle = ($urandom_range(0, 2) != 0);
                    rx_idle = ($urandom_range(0, 2) != 0);
                end
                // receiver backs off while the sender streams at full rate
                if (ph == 1 && n == 10)
                begin
                    tx_idle   = 1'b0;
                    long_hold = 1'b1;
                end
                it = '0;
                if ($urandom_range(0, 99) < 80)
                    it.sample_index = pool_base + SAMPLE_BITS'($urandom_range(0, 7));
                else
                    it.sample_index = SAMPLE_BITS'($urandom_range(0, 1023));
                it.site_index = SITE_BITS'($urandom_range(0, 'hFFFFFF));
                if ($urandom_range(0, 99) < 8)
                begin
                    it.true_a = 2'($urandom_range(0, 3));
                    it.true_b = 2'($urandom_range(2, 3));
                    if ($urandom_range(0, 1) != 0)
                    begin
                        tmp       = it.true_a;
                        it.true_a = it.true_b;
                        it.true_b = tmp;
                    end
                end
                else
                begin
                    it.true_a = 2'($urandom_range(0, 1));
                    it.true_b = 2'($urandom_range(0, 1));
                end
                k = $urandom_range(0, 99);
                if (k < 8)
                begin
                    it.est_a = 2'($urandom_range(0, 3));
                    it.est_b = 2'($urandom_range(2, 3));
                    if ($urandom_range(0, 1) != 0)
                    begin
                        tmp      = it.est_a;
                        it.est_a = it.est_b;
                        it.est_b = tmp;
                    end
                end
                else if (k < 70)
                begin
                    it.est_a = {1'b0, it.true_a[0]};
                    it.est_b = {1'b0, it.true_b[0]};
                end
                else if (k < 88)
                begin
                    it.est_a = {1'b0, it.true_b[0]};
                    it.est_b = {1'b0, it.true_a[0]};
                end
                else
                begin
                    it.est_a = 2'($urandom_range(0, 1));
                    it.est_b = 2'($urandom_range(0, 1));
                end
                it.partner_true_a = 1'($urandom_range(0, 1));
                it.partner_true_b = 1'($urandom_range(0, 1));
                // repeat the sample's last class often so confident classes get credited
                if ($urandom_range(0, 99) < 60)
                    it.ancestry_class = anc_hint[it.sample_index];
                else
                    it.ancestry_class = 2'($urandom_range(0, 3));
                anc_hint[it.sample_index] = it.ancestry_class;
                send_site(it, 1'b0, OUT_COMPARED, 1'b0, 1'b0);
            end
        end

        s_tvalid <= 1'b0;
        while (site_scores_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
